[src/frame_state_hasher_core_defines.svh]
// ----------------------------------------------------------------------------
// frame_state_hasher_core_defines
// Assertion macros shared by the frame state hasher modules. Each macro
// expects signals named clk and rst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef FRAME_STATE_HASHER_CORE_DEFINES_SVH
`define FRAME_STATE_HASHER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold on every clock edge out of reset
`define FSH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define FSH_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define FSH_ASSERT(lbl, prop, msg)
`define FSH_NEVER(lbl, expr, msg)

`endif

`endif

[src/fsh_pkg.sv]
// ----------------------------------------------------------------------------
// fsh_pkg
// Types and constants of the frame state hasher: mixer constants, field
// positions, controller states and the command and status groups.
// ----------------------------------------------------------------------------
package fsh_pkg;

  // murmur3 64-bit finaliser constants
  localparam logic [63:0] MIX_MUL_A  = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B  = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SHIFT  = 33;

  // hash combine constant
  localparam logic [63:0] GOLDEN_ADD = 64'h000000009e3779b9;

  // positions of the frame-level terms
  localparam int STAGE_POS = 40;
  localparam int MATCH_POS = 48;

  // a 64 x 64 low-half product takes three 32 x 32 partial products
  localparam int MUL_STEPS = 3;
  localparam logic [1:0] MUL_STEP_LO  = 2'd0;
  localparam logic [1:0] MUL_STEP_KHI = 2'd1;
  localparam logic [1:0] MUL_STEP_WHI = 2'(MUL_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_FOLD1,
    ST_FOLD2,
    ST_EMIT
  } fsh_state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       mul_sel_b;
    logic       fold1;
    logic       fold2;
    logic       emit;
  } fsh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } fsh_stat_t;

endpackage

[src/fsh_in_if.sv]
// ----------------------------------------------------------------------------
// fsh_in_if
// Slot request channel: valid/ready handshake with one character slot.
// ----------------------------------------------------------------------------
interface fsh_in_if;
  logic        valid;
  logic        ready;
  logic        slot_active;
  logic [7:0]  char_id;
  logic [15:0] anim_state;
  logic [15:0] anim_count;
  logic [7:0]  facing;
  logic [7:0]  palette;
  logic [7:0]  stage_code;
  logic [7:0]  battle_flag;
  logic        last_slot;

  modport source (
    output valid, slot_active, char_id, anim_state, anim_count, facing,
           palette, stage_code, battle_flag, last_slot,
    input  ready
  );

  modport sink (
    input  valid, slot_active, char_id, anim_state, anim_count, facing,
           palette, stage_code, battle_flag, last_slot,
    output ready
  );
endinterface

[src/fsh_out_if.sv]
// ----------------------------------------------------------------------------
// fsh_out_if
// Frame hash channel: valid/ready handshake with one 64-bit hash.
// ----------------------------------------------------------------------------
interface fsh_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] frame_hash;

  modport source (
    output valid, frame_hash,
    input  ready
  );

  modport sink (
    input  valid, frame_hash,
    output ready
  );
endinterface

[src/fsh_ctrl.sv]
// ----------------------------------------------------------------------------
// fsh_ctrl
// Sequencer of the hasher: steps the shared multiplier through both mixer
// products, the two fold steps and, after a last slot, the frame hash emit.
// ----------------------------------------------------------------------------
`include "frame_state_hasher_core_defines.svh"

module fsh_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_slot_active,
  input  logic              in_last_slot,
  output logic              in_ready,
  input  fsh_pkg::fsh_stat_t stat,
  output fsh_pkg::fsh_cmd_t  cmd
);

  fsh_pkg::fsh_state_t state_r, state_nxt;
  logic [1:0]          step_r, step_nxt;
  logic                last_r, last_nxt;
  logic                accept;

  assign accept = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fsh_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_slot_active) begin
            state_nxt = fsh_pkg::ST_MUL_A;
          end else if (in_last_slot) begin
            state_nxt = fsh_pkg::ST_EMIT;
          end
        end
      end
      fsh_pkg::ST_MUL_A: begin
        if (step_r == fsh_pkg::MUL_STEP_WHI) state_nxt = fsh_pkg::ST_MUL_B;
      end
      fsh_pkg::ST_MUL_B: begin
        if (step_r == fsh_pkg::MUL_STEP_WHI) state_nxt = fsh_pkg::ST_FOLD1;
      end
      fsh_pkg::ST_FOLD1: state_nxt = fsh_pkg::ST_FOLD2;
      fsh_pkg::ST_FOLD2: begin
        state_nxt = last_r ? fsh_pkg::ST_EMIT : fsh_pkg::ST_IDLE;
      end
      fsh_pkg::ST_EMIT: begin
        if (stat.out_free) state_nxt = fsh_pkg::ST_IDLE;
      end
      default: state_nxt = fsh_pkg::ST_IDLE;
    endcase
  end

  // partial product counter and last-slot flag
  always_comb begin
    step_nxt = fsh_pkg::MUL_STEP_LO;
    if (state_r == fsh_pkg::ST_MUL_A || state_r == fsh_pkg::ST_MUL_B) begin
      if (step_r != fsh_pkg::MUL_STEP_WHI) step_nxt = step_r + 2'd1;
    end
    last_nxt = accept ? in_last_slot : last_r;
  end

  // outputs
  always_comb begin
    in_ready      = (state_r == fsh_pkg::ST_IDLE) && rst_n;
    cmd.load      = accept;
    cmd.mul_en    = (state_r == fsh_pkg::ST_MUL_A) || (state_r == fsh_pkg::ST_MUL_B);
    cmd.mul_step  = step_r;
    cmd.mul_sel_b = (state_r == fsh_pkg::ST_MUL_B);
    cmd.fold1     = (state_r == fsh_pkg::ST_FOLD1);
    cmd.fold2     = (state_r == fsh_pkg::ST_FOLD2);
    cmd.emit      = (state_r == fsh_pkg::ST_EMIT) && stat.out_free;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsh_pkg::ST_IDLE;
      step_r  <= fsh_pkg::MUL_STEP_LO;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
    end
  end

  // checks
  `FSH_ASSERT(a_idle_step_zero, in_ready |-> (step_r == fsh_pkg::MUL_STEP_LO), "step counter not cleared in idle")
  `FSH_NEVER(a_emit_blocked, cmd.emit && !stat.out_free, "emit while output register is held")
  `FSH_ASSERT(a_active_starts_mul, (accept && in_slot_active) |=> (state_r == fsh_pkg::ST_MUL_A), "active slot did not start mixing")

endmodule

[src/fsh_dp.sv]
// ----------------------------------------------------------------------------
// fsh_dp
// Datapath of the hasher: slot packing, a shared 32 x 32 multiplier with
// accumulator for the finaliser, the hash combine fold and the output register.
// ----------------------------------------------------------------------------
`include "frame_state_hasher_core_defines.svh"

module fsh_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  fsh_pkg::fsh_cmd_t  cmd,
  output fsh_pkg::fsh_stat_t stat,
  input  logic [7:0]        in_char_id,
  input  logic [15:0]       in_anim_state,
  input  logic [15:0]       in_anim_count,
  input  logic [7:0]        in_facing,
  input  logic [7:0]        in_palette,
  input  logic [7:0]        in_stage_code,
  input  logic [7:0]        in_battle_flag,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [63:0]       out_frame_hash
);

  logic [63:0] w_r, w_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [7:0]  stage_r, stage_nxt;
  logic [7:0]  match_r, match_nxt;
  logic [63:0] frame_hash_r, frame_hash_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [63:0] pack;
  logic [63:0] mul_k;
  logic [31:0] op_w;
  logic [31:0] op_k;
  logic [63:0] prod;
  logic [63:0] acc_sum;
  logic [63:0] frame_terms;

  // slot word; its first xor-shift is applied on load
  assign pack = {8'd0, in_char_id, in_anim_state, in_anim_count, in_facing, in_palette};

  // operand selection for the shared multiplier
  always_comb begin
    mul_k = cmd.mul_sel_b ? fsh_pkg::MIX_MUL_B : fsh_pkg::MIX_MUL_A;
    op_w  = (cmd.mul_step == fsh_pkg::MUL_STEP_WHI) ? w_r[63:32] : w_r[31:0];
    op_k  = (cmd.mul_step == fsh_pkg::MUL_STEP_KHI) ? mul_k[63:32] : mul_k[31:0];
    prod  = 64'(op_w) * 64'(op_k);
    acc_sum = acc_r + {prod[31:0], 32'd0};
  end

  assign frame_terms = (64'(stage_r) << fsh_pkg::STAGE_POS)
                     ^ (64'(match_r) << fsh_pkg::MATCH_POS);

  // next values
  always_comb begin
    w_nxt          = w_r;
    acc_nxt        = acc_r;
    hash_nxt       = hash_r;
    stage_nxt      = stage_r;
    match_nxt      = match_r;
    frame_hash_nxt = frame_hash_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (cmd.load) begin
      w_nxt     = pack ^ (pack >> fsh_pkg::MIX_SHIFT);
      stage_nxt = in_stage_code;
      match_nxt = in_battle_flag;
    end

    if (cmd.mul_en) begin
      if (cmd.mul_step == fsh_pkg::MUL_STEP_LO) begin
        acc_nxt = prod;
      end else if (cmd.mul_step == fsh_pkg::MUL_STEP_KHI) begin
        acc_nxt = acc_sum;
      end else begin
        w_nxt = acc_sum ^ (acc_sum >> fsh_pkg::MIX_SHIFT);
      end
    end

    // hash combine in two steps: fold1, then fold2
    if (cmd.fold1) begin
      acc_nxt = w_r + (hash_r << 6);
    end
    if (cmd.fold2) begin
      hash_nxt = hash_r ^ (acc_r + (hash_r >> 2) + fsh_pkg::GOLDEN_ADD);
    end

    if (cmd.emit) begin
      frame_hash_nxt = hash_r ^ frame_terms;
      out_valid_nxt  = 1'b1;
      hash_nxt       = 64'd0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r      <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    acc_r        <= acc_nxt;
    stage_r      <= stage_nxt;
    match_r      <= match_nxt;
    frame_hash_r <= frame_hash_nxt;
  end

  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_frame_hash  = frame_hash_r;

  // checks
  `FSH_ASSERT(a_emit_clears_hash, cmd.emit |=> (out_valid_r && hash_r == 64'd0), "hash not cleared on emit")
  `FSH_ASSERT(a_held_result_stable, (out_valid_r && !out_ready) |=> (out_valid_r && $stable(frame_hash_r)), "held result changed")

endmodule

[src/frame_state_hasher_core.sv]
// ----------------------------------------------------------------------------
// frame_state_hasher_core
// Hashes the character slots of one frame into a 64-bit frame hash.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one character slot per request; out_ch carries one
//   frame hash per frame, sent after the request flagged last_slot.
//   An active slot is mixed with the 64-bit finaliser on one shared
//   32 x 32 multiplier, three partial products per 64-bit multiply, then
//   folded into the running hash in two steps.
//   An active slot holds the input through the mixing and fold states;
//   an inactive slot does not hold it. A last slot adds the emit state,
//   which waits for the output register to be free. The frame hash is
//   emitted from that state, entered after the fold states for an active
//   last slot and straight from idle for an inactive one; out_valid and
//   out_frame_hash are registered.
//   Reset clears the running hash and drops both valid and ready control.
//   A stalled receiver holds the result in the output register; further
//   slots are still taken, and only the next emit waits for it to leave.
// ----------------------------------------------------------------------------
module frame_state_hasher_core (
  input  logic      clk,
  input  logic      rst_n,
  fsh_in_if.sink    in_ch,
  fsh_out_if.source out_ch
);

  fsh_pkg::fsh_cmd_t  cmd;
  fsh_pkg::fsh_stat_t stat;

  // sequencer
  fsh_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_slot_active (in_ch.slot_active),
    .in_last_slot   (in_ch.last_slot),
    .in_ready       (in_ch.ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  // mixer, fold and output register
  fsh_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_char_id     (in_ch.char_id),
    .in_anim_state  (in_ch.anim_state),
    .in_anim_count  (in_ch.anim_count),
    .in_facing      (in_ch.facing),
    .in_palette     (in_ch.palette),
    .in_stage_code  (in_ch.stage_code),
    .in_battle_flag (in_ch.battle_flag),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_frame_hash (out_ch.frame_hash)
  );

endmodule
